// ===== rtl/core/keyframe_vector_interpolator_assert.svh =====
// Assertion macros for the keyframe interpolator
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH

// Property that must hold on every clock edge out of reset
`define KVI_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge
`define KVI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kvi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared codes and types of the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SINGLE  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_CLAMPED = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  key_time;
        logic [WORD_W-1:0]  key_x;
        logic [WORD_W-1:0]  key_y;
        logic [WORD_W-1:0]  key_z;
        logic [WORD_W-1:0]  query_time;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/kvi_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module kvi_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_wr_valid,
    output logic          o_wr_ready,
    input  kvi_pkg::t_cmd i_wr_data,
    output logic          o_rd_valid,
    input  wire           i_rd_ready,
    output kvi_pkg::t_cmd o_rd_data
);
    import kvi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/kvi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_front
// Input stage: registers an item.
// ----------------------------------------------------------------------------
module kvi_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  kvi_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  wire           i_ready,
    output kvi_pkg::t_cmd o_cmd
);
    import kvi_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/kvi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_back
// Executes commands: key store, linear search, serial divide, blend.
// ----------------------------------------------------------------------------
module kvi_back #(
    parameter int unsigned MAX_KEYS  = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  kvi_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output kvi_pkg::t_status    o_status
);
    import kvi_pkg::*;

    localparam int unsigned AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW  = $clog2(MAX_KEYS + 1);
    localparam int unsigned DW  = WORD_W + FRAC_BITS;    // dividend width
    localparam int unsigned DCW = $clog2(DW + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_KEYS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_W0, S_SRCH, S_SW, S_LAST, S_SEG0, S_SEG1, S_DIV,
        S_BL, S_BLW, S_OUT
    } t_state;

    logic [31:0] m_time [MAX_KEYS];
    logic [31:0] m_x [MAX_KEYS];
    logic [31:0] m_y [MAX_KEYS];
    logic [31:0] m_z [MAX_KEYS];

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_addr;
    logic [31:0]     r_rt, r_rx, r_ry, r_rz;
    logic [31:0]     r_q;
    logic [AW-1:0]   r_i;
    logic [31:0]     r_a_x, r_a_y, r_a_z;
    logic [DW-1:0]   r_num;
    logic [WORD_W:0] r_rem;
    logic [31:0]     r_den;
    logic [DW-1:0]   r_quo;
    logic [DCW-1:0]  r_dcnt;
    logic [1:0]      r_comp;
    logic signed [FRAC_BITS+34:0] r_prod;
    logic            r_valid;
    logic signed [31:0] r_ox, r_oy, r_oz;
    t_status         r_st;

    logic [WORD_W:0] w_trial;
    logic [WORD_W:0] w_sub;
    logic signed [32:0] w_delta;
    logic signed [31:0] w_a_sel, w_b_sel;
    logic signed [FRAC_BITS+1:0] w_f;
    logic signed [FRAC_BITS+34:0] w_round;
    logic signed [31:0] w_res;

    assign o_ready  = (r_state == S_IDLE) && !r_valid;
    assign o_valid  = r_valid;
    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_out_z  = r_oz;
    assign o_status = r_st;

    // one restoring step a cycle
    assign w_trial = {r_rem[WORD_W-1:0], r_num[DW-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_comb begin
        case (r_comp)
            2'd0:    begin w_a_sel = r_a_x; w_b_sel = r_rx; end
            2'd1:    begin w_a_sel = r_a_y; w_b_sel = r_ry; end
            default: begin w_a_sel = r_a_z; w_b_sel = r_rz; end
        endcase
    end
    assign w_delta = {w_b_sel[31], w_b_sel} - {w_a_sel[31], w_a_sel};
    assign w_f     = {2'b00, r_quo[FRAC_BITS-1:0]};
    assign w_round = (r_prod + (FRAC_BITS+35)'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign w_res   = w_a_sel + w_round[31:0];

    always_ff @(posedge i_clk) begin
        r_rt <= m_time[r_addr];
        r_rx <= m_x[r_addr];
        r_ry <= m_y[r_addr];
        r_rz <= m_z[r_addr];
        if (o_ready && i_valid && i_cmd.op == OP_APPEND && r_cnt != FULL_CNT) begin
            m_time[r_cnt[AW-1:0]] <= i_cmd.key_time;
            m_x[r_cnt[AW-1:0]]    <= i_cmd.key_x;
            m_y[r_cnt[AW-1:0]]    <= i_cmd.key_y;
            m_z[r_cnt[AW-1:0]]    <= i_cmd.key_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_addr  <= '0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_ready && i_valid) begin
                        r_ox <= '0; r_oy <= '0; r_oz <= '0;
                        r_q  <= i_cmd.query_time;
                        case (i_cmd.op)
                            OP_APPEND: begin
                                if (r_cnt == FULL_CNT) r_st <= ST_FULL;
                                else begin
                                    r_st  <= ST_OK;
                                    r_cnt <= r_cnt + CW'(1);
                                end
                                r_valid <= 1'b1;
                            end
                            OP_CLEAR: begin
                                r_st    <= ST_OK;
                                r_cnt   <= '0;
                                r_valid <= 1'b1;
                            end
                            OP_QUERY: begin
                                if (r_cnt == '0) begin
                                    r_st <= ST_EMPTY;
                                    r_valid <= 1'b1;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_addr  <= '0;
                                    r_state <= S_RD0;
                                end
                            end
                            default: begin
                                r_st    <= ST_OK;
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD0: r_state <= S_W0;    // wait for the registered read of key 0
                S_W0: begin
                    r_ox <= r_rx; r_oy <= r_ry; r_oz <= r_rz;
                    if (r_cnt == CW'(1)) begin
                        r_st <= ST_SINGLE; r_state <= S_OUT;
                    end else if (r_q < r_rt) begin
                        r_st <= ST_CLAMPED; r_state <= S_OUT;
                    end else begin
                        r_i <= '0;
                        r_addr <= AW'(1);
                        r_state <= S_SW;
                    end
                end
                S_SW: r_state <= S_SRCH;
                S_SRCH: begin
                    // r_rt holds key r_i+1
                    if (r_q < r_rt) begin
                        r_addr  <= r_i;
                        r_state <= S_SEG0;
                    end else if (CW'(r_i) + CW'(2) >= r_cnt) begin
                        r_ox <= r_rx; r_oy <= r_ry; r_oz <= r_rz;
                        r_st <= (r_q > r_rt) ? ST_CLAMPED : ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        r_i    <= r_i + AW'(1);
                        r_addr <= r_i + AW'(2);
                        r_state <= S_SW;
                    end
                end
                S_SEG0: begin
                    // capture end key now, start key next
                    r_den <= r_rt; r_a_x <= r_rx; r_a_y <= r_ry; r_a_z <= r_rz;
                    r_addr <= r_i + AW'(1);
                    r_state <= S_SEG1;
                end
                S_SEG1: begin
                    r_a_x <= r_rx; r_a_y <= r_ry; r_a_z <= r_rz;
                    r_den <= r_den - r_rt;
                    r_num <= (r_q > r_rt) ? (DW'(r_q - r_rt) << FRAC_BITS) : '0;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_dcnt <= DCW'(DW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= r_num << 1;
                    if (!w_sub[WORD_W]) begin
                        r_rem <= w_sub;
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_comp <= 2'd0;
                        r_addr <= r_i + AW'(1);
                        r_state <= S_BL;
                    end
                end
                S_BL: begin
                    r_prod  <= (FRAC_BITS+35)'(w_f * w_delta);
                    r_state <= S_BLW;
                end
                S_BLW: begin
                    case (r_comp)
                        2'd0:    r_ox <= w_res;
                        2'd1:    r_oy <= w_res;
                        default: r_oz <= w_res;
                    endcase
                    r_st <= ST_OK;
                    if (r_comp == 2'd2) r_state <= S_OUT;
                    else begin
                        r_comp <= r_comp + 2'd1;
                        r_state <= S_BL;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/keyframe_vector_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator
// Keyframe table with linear search and linear blending of xyz vectors.
// ----------------------------------------------------------------------------
// Every item (append, query, clear, no operation) yields exactly one result.
// A query runs a linear search over the keys, reading and comparing one key
// at a time through the key memory port, then a restoring divider that forms
// the blend factor, then the three blends on a shared multiplier. A front
// register and a two-entry queue take items while the back end works.
// Key memories need no clearing: entries at or above the key count are
// never used. Undefined op codes act as no operation.
module keyframe_vector_interpolator #(
    parameter int unsigned MAX_KEYS  = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire [1:0]          i_op,
    input  wire [31:0]         i_key_time,
    input  wire signed [31:0]  i_key_x,
    input  wire signed [31:0]  i_key_y,
    input  wire signed [31:0]  i_key_z,
    input  wire [31:0]         i_query_time,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [2:0]         o_status
);
    import kvi_pkg::*;

    t_cmd    w_in_cmd, w_f_cmd, w_q_cmd;
    logic    w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    t_status w_status;
    logic    w_stall;
    logic    w_out_zero;

    // pack the item
    assign w_in_cmd.op         = t_op'(i_op);
    assign w_in_cmd.key_time   = i_key_time;
    assign w_in_cmd.key_x      = i_key_x;
    assign w_in_cmd.key_y      = i_key_y;
    assign w_in_cmd.key_z      = i_key_z;
    assign w_in_cmd.query_time = i_query_time;

    kvi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(w_in_cmd),
        .o_valid(w_f_valid), .i_ready(w_f_ready), .o_cmd(w_f_cmd)
    );

    kvi_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(w_f_valid), .o_wr_ready(w_f_ready), .i_wr_data(w_f_cmd),
        .o_rd_valid(w_q_valid), .i_rd_ready(w_q_ready), .o_rd_data(w_q_cmd)
    );

    kvi_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_status(w_status)
    );

    assign o_status = w_status;

    // result waiting on the receiver, and an all-zero vector
    assign w_stall    = o_valid && !i_ready;
    assign w_out_zero = ((o_out_x | o_out_y | o_out_z) == 32'sd0);

`include "keyframe_vector_interpolator_assert.svh"

    // hold a stalled result
    `KVI_ASSERT_NEXT(a_out_hold, w_stall, o_valid && $stable(o_status), "stalled result moved")
    // back end takes no item while a result waits
    `KVI_ASSERT_CLK(a_back_busy, !(o_valid && w_q_ready), "back end ready with result pending")
    // a full status carries a zero vector
    `KVI_ASSERT_CLK(a_full_zero, !(o_valid && w_status == ST_FULL) || w_out_zero, "full with data")

endmodule
`default_nettype wire
